### design/assert_macros.svh
// shared assertion macros for the sanitizer checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// boolean condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/utss_pkg.sv
// ----------------------------------------------------------------------------
// utss_pkg
// Types, byte codes and the lead byte decode shared by the sanitizer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package utss_pkg;

	// result slots per item: four groups of three bytes
	localparam int SLOTS = 12;

	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_DEL    = 8'd127;
	localparam logic [7:0] CH_EURO   = 8'd128;
	localparam logic [7:0] CH_NEL    = 8'd133;
	localparam logic [7:0] CH_NBSP   = 8'd160;
	localparam logic [7:0] LEAD_C0   = 8'd192;
	localparam logic [7:0] LEAD_C2   = 8'd194;
	localparam logic [7:0] LEAD_C3   = 8'd195;
	localparam logic [7:0] LEAD_E0   = 8'd224;
	localparam logic [7:0] LEAD_E2   = 8'd226;
	localparam logic [7:0] LEAD_F0   = 8'd240;
	localparam logic [7:0] LEAD_BAD  = 8'd245;
	localparam logic [7:0] EURO_B1   = 8'd130;
	localparam logic [7:0] EURO_B2   = 8'd172;
	localparam logic [7:0] LATIN_OFS = 8'd64;

	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [2:0]      mask;
		logic            hold;
	} lead_t;

	typedef struct packed {
		logic [SLOTS-1:0][7:0] bytes;
		logic [SLOTS-1:0]      mask;
	} slots_t;

	// decode of one byte taken as the start of a character
	function automatic lead_t take_lead(input logic [7:0] c, input logic last);
		lead_t r;
		r = '0;
		priority if (c < CH_SPACE) begin
			if (c == CH_TAB || c == CH_LF || c == CH_CR) begin
				r.bytes[0] = c;
				r.mask     = 3'b001;
			end
		end else if (c < CH_DEL) begin
			r.bytes[0] = c;
			r.mask     = 3'b001;
		end else if (c < CH_NBSP) begin
			if (c == CH_EURO) begin
				r.bytes[0] = LEAD_E2;
				r.bytes[1] = EURO_B1;
				r.bytes[2] = EURO_B2;
				r.mask     = 3'b111;
			end else if (c == CH_NEL) begin
				r.bytes[0] = CH_LF;
				r.bytes[1] = CH_CR;
				r.mask     = 3'b011;
			end
		end else if (c < LEAD_C0) begin
			r.bytes[0] = LEAD_C2;
			r.bytes[1] = c;
			r.mask     = 3'b011;
		end else if (c < LEAD_C2 || c >= LEAD_BAD || last) begin
			r.bytes[0] = LEAD_C3;
			r.bytes[1] = c - LATIN_OFS;
			r.mask     = 3'b011;
		end else begin
			r.hold = 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### design/utss_core.sv
// ----------------------------------------------------------------------------
// utss_core
// Input register, held sequence state and the per-item decode into slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utss_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [7:0]      data_byte,
	input  wire logic            end_of_string,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            buf_free,
	output logic                 load,
	output utss_pkg::slots_t     slots
);
	import utss_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eos_s1;

	logic [2:0][7:0] held_q;
	logic [1:0]      cnt_q;

	logic [1:0] need;
	logic       cont;
	logic       do_hold;
	logic       do_append;
	logic [1:0] cnt_d;
	lead_t      seg_lead;
	lead_t      seg_c1;
	lead_t      seg_c2;

	assign load     = valid_s1 & buf_free;
	assign in_ready = ~valid_s1 | buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			eos_s1  <= end_of_string;
		end
	end

	assign need = (held_q[0] < LEAD_E0) ? 2'd1 : ((held_q[0] < LEAD_F0) ? 2'd2 : 2'd3);
	assign cont = (data_s1[7:6] == 2'b10);

	always_comb begin
		seg_lead  = take_lead(data_s1, eos_s1);
		seg_c1    = take_lead(held_q[1], 1'b0);
		seg_c2    = take_lead(held_q[2], 1'b0);
		slots     = '0;
		do_hold   = 1'b0;
		do_append = 1'b0;
		cnt_d     = 2'd0;
		if (cnt_q == 2'd0) begin
			slots.bytes[2:0] = seg_lead.bytes;
			slots.mask[2:0]  = seg_lead.mask;
			do_hold          = seg_lead.hold;
			cnt_d            = {1'b0, seg_lead.hold};
		end else if (cont && cnt_q == need) begin
			// complete sequence; C2 with 80..9F is a C1 control and goes away
			if (!(need == 2'd1 && held_q[0] == LEAD_C2 && data_s1 < CH_NBSP)) begin
				for (int i = 0; i < 3; i++) begin
					slots.bytes[i] = held_q[i];
					slots.mask[i]  = (2'(i) < cnt_q);
				end
				slots.bytes[3] = data_s1;
				slots.mask[3]  = 1'b1;
			end
		end else if (cont && !eos_s1) begin
			do_append = 1'b1;
			cnt_d     = cnt_q + 2'd1;
		end else begin
			// broken sequence: lead as latin-1, held bytes and new byte as leads
			slots.bytes[0]    = LEAD_C3;
			slots.bytes[1]    = held_q[0] - LATIN_OFS;
			slots.mask[1:0]   = 2'b11;
			slots.bytes[5:3]  = seg_c1.bytes;
			slots.mask[5:3]   = (cnt_q >= 2'd2) ? seg_c1.mask : 3'b000;
			slots.bytes[8:6]  = seg_c2.bytes;
			slots.mask[8:6]   = (cnt_q == 2'd3) ? seg_c2.mask : 3'b000;
			slots.bytes[11:9] = seg_lead.bytes;
			slots.mask[11:9]  = seg_lead.mask;
			do_hold           = seg_lead.hold;
			cnt_d             = {1'b0, seg_lead.hold};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (do_hold) begin
				held_q[0] <= data_s1;
			end else if (do_append) begin
				unique case (cnt_q)
					2'd1:    held_q[1] <= data_s1;
					2'd2:    held_q[2] <= data_s1;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

### design/utss_outbuf.sv
// ----------------------------------------------------------------------------
// utss_outbuf
// Result register: holds the slots of one item and sends them one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utss_outbuf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire utss_pkg::slots_t slots,
	output logic                  buf_free,
	output logic [7:0]            out_byte,
	output logic                  run_last,
	output logic                  out_valid,
	input  wire logic             out_ready
);
	import utss_pkg::*;

	logic [SLOTS-1:0][7:0] bytes_q;
	logic [SLOTS-1:0]      mask_q;
	logic [SLOTS-1:0]      first;
	logic [SLOTS-1:0]      rest;
	logic                  take;

	// lowest pending slot goes out first
	assign first     = mask_q & (~mask_q + SLOTS'(1));
	assign rest      = mask_q & ~first;
	assign out_valid = |mask_q;
	assign run_last  = (rest == '0);
	assign take      = out_valid & out_ready;
	assign buf_free  = ~out_valid | (take & run_last);

	always_comb begin
		out_byte = '0;
		for (int i = 0; i < SLOTS; i++) begin
			out_byte = out_byte | (bytes_q[i] & {8{first[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= slots.mask;
		end else if (take) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= slots.bytes;
		end
	end

endmodule

`default_nettype wire

### design/utf8_stream_sanitizer_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer_unit
// Streaming UTF-8 cleaner with latin-1 repair, one raw byte per input item.
// ----------------------------------------------------------------------------
// Usage:
//   input channel in_valid/in_ready carries data_byte and end_of_string;
//   end_of_string marks the last byte of a string and flushes held bytes.
//   output channel out_valid/out_ready carries out_byte and run_last; run_last
//   marks the last byte caused by one input item (an item may cause none).
//   path: an accepted item is held in the input register, decoded
//   combinationally and loaded into the result register once that is free;
//   its bytes are offered from the result register.
//   throughput: the result register sends one byte per cycle while out_ready
//   is high; the input register takes the next item while results are still
//   draining.
//   a stalled receiver holds the current byte; once the result register and
//   the input register are both full, in_ready drops.
//   reset clears the valid flags and the held-byte count; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_sanitizer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_string,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            out_valid,
	input  wire logic       out_ready
);
	import utss_pkg::*;

	logic   buf_free;
	logic   load;
	slots_t slots;

	utss_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (data_byte),
		.end_of_string (end_of_string),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.buf_free      (buf_free),
		.load          (load),
		.slots         (slots)
	);

	utss_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.slots     (slots),
		.buf_free  (buf_free),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

`default_nettype wire

### design/utss_checker.sv
// ----------------------------------------------------------------------------
// utss_checker
// Port-level checks for the sanitizer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utss_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic [7:0] data_byte,
	input wire logic       end_of_string,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] out_byte,
	input wire logic       run_last,
	input wire logic       out_valid,
	input wire logic       out_ready
);

	// a stalled input item keeps its payload
	`ASSERT_CLK(a_in_hold, clk, arst_n, (in_valid && !in_ready) |=> (in_valid && $stable(data_byte) && $stable(end_of_string)), "input item changed while stalled")

	// a stalled result keeps its payload
	`ASSERT_CLK(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(run_last)), "result item changed while stalled")

	// only tab, lf and cr survive among the control bytes, and del never does
	`ASSERT_NEVER(a_no_ctrl, clk, arst_n, out_valid && ((out_byte < 8'd32 && out_byte != 8'd9 && out_byte != 8'd10 && out_byte != 8'd13) || out_byte == 8'd127), "control byte in output")

	// overlong and out-of-range leads never reach the output
	`ASSERT_NEVER(a_no_bad_lead, clk, arst_n, out_valid && (out_byte == 8'd192 || out_byte == 8'd193 || out_byte >= 8'd245), "invalid lead byte in output")

endmodule

bind utf8_stream_sanitizer_unit utss_checker u_chk (.*);

`default_nettype wire
